// ----- hw/rtl/rst_voltage_controller_core_defines.svh -----
// assertion macros shared by the voltage controller rtl
// each use expects clk and rst_n in scope
`ifndef RST_VOLTAGE_CONTROLLER_CORE_DEFINES_SVH
`define RST_VOLTAGE_CONTROLLER_CORE_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define RVC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rvc assertion failed");
// next-cycle implication
`define RVC_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rvc assertion failed");
`else
`define RVC_ASSERT_IMP(label, ante, cons)
`define RVC_ASSERT_NXT(label, ante, cons)
`endif

`endif

// ----- hw/rtl/rvc_pkg.sv -----
`timescale 1ns / 1ps

package rvc_pkg;

    // field widths
    localparam int VOLT_W = 24;
    localparam int DUTY_W = 16;
    localparam int COEF_W = 32;
    localparam int FRAC_W = 30;
    localparam int OPND_W = VOLT_W + 1;
    localparam int PROD_W = COEF_W + OPND_W;
    localparam int ACC_W  = PROD_W + 1;

    // tap sequencing
    localparam int NUM_SETS  = 3;
    localparam int NUM_TAPS  = 14;
    localparam int TAP_W     = 4;
    localparam int RING_W    = 3;
    localparam int REGION_W  = 2;
    localparam int ADDR_W    = REGION_W + RING_W;
    localparam int MEM_DEPTH = 24;
    localparam logic [TAP_W-1:0]  LAST_STEP = TAP_W'(NUM_TAPS + 1);
    localparam logic [RING_W-1:0] FILL_MAX  = '1;

    // history regions in the memory
    localparam logic [REGION_W-1:0] REGION_SETPOINT = 2'd0;
    localparam logic [REGION_W-1:0] REGION_MEASURED = 2'd1;
    localparam logic [REGION_W-1:0] REGION_DUTY     = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_COEFFICIENT_SET = 2'd0;
    localparam logic [1:0] REG_DUTY_MAX        = 2'd1;
    localparam logic [1:0] REG_DUTY_MIN        = 2'd2;

    localparam logic [1:0]        COEF_SET_RESET = 2'd0;
    localparam logic [DUTY_W-1:0] DUTY_MAX_RESET = 16'd52429;
    localparam logic [DUTY_W-1:0] DUTY_MIN_RESET = 16'd13107;

    // clamp flags
    localparam logic [1:0] CLAMP_NONE     = 2'd0;
    localparam logic [1:0] CLAMP_MAX      = 2'd1;
    localparam logic [1:0] CLAMP_MIN      = 2'd2;
    localparam logic [1:0] CLAMP_RESERVED = 2'd3;

    localparam logic [1:0] SET_30V = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        SRC_SETPOINT,
        SRC_MEASURED,
        SRC_HISTORY
    } src_t;

    // control from the sequencer to the multiply-accumulate datapath
    typedef struct packed {
        logic                clear;
        logic                issue;
        logic [TAP_W-1:0]    tap;
        logic [RING_W-1:0]   ptr;
        logic [RING_W-1:0]   fill;
        logic [1:0]          coef_sel;
        logic                wr_en;
        logic [ADDR_W-1:0]   wr_addr;
        logic [VOLT_W-1:0]   wr_data;
    } mac_ctrl_t;

    // decimal design value (scaled by 1e18) to Q2.30, round to nearest
    localparam longint DEC_DIV  = 64'sd3814697265625;
    localparam longint DEC_HALF = 64'sd1907348632812;

    function automatic logic signed [COEF_W-1:0] qp(longint n);
        longint r;
        r = (n / DEC_DIV) * 64'sd4096 + ((n % DEC_DIV) * 64'sd4096 + DEC_HALF) / DEC_DIV;
        return r[COEF_W-1:0];
    endfunction

    function automatic logic signed [COEF_W-1:0] qn(longint n);
        logic signed [COEF_W-1:0] p;
        p = qp(n);
        return -p;
    endfunction

    // gains in tap order, feedback signs folded in:
    // +T0..T6, -R0..R2, -S0..S3
    localparam logic signed [COEF_W-1:0] GAIN_ROM [NUM_SETS][NUM_TAPS] = '{
        '{ qp(64'sd124732432687515000), qn(64'sd293247941102856000),
           qp(64'sd238023909270153000), qn(64'sd81325514552102300),
           qp(64'sd13502518502660300),  qn(64'sd1088265631159850),
           qp(64'sd34258207928936),
           qn(64'sd29310260250540400),  qp(64'sd87850910177262600),
           qn(64'sd59172047308861000),
           qp(64'sd824013588416498000), qp(64'sd167463757771437000),
           qp(64'sd8816390042478200),   qn(64'sd293736230412986) },
        '{ qp(64'sd123301471407425000), qn(64'sd289883728282318000),
           qp(64'sd235293240184636000), qn(64'sd80392528159549700),
           qp(64'sd13347614274909000),  qn(64'sd1075780779008010),
           qp(64'sd33865189304867),
           qn(64'sd53303321780020100),  qp(64'sd117758097920058000),
           qn(64'sd65078929975436800),
           qp(64'sd777974596450532000), qp(64'sd213542950626117000),
           qp(64'sd8776189153764530),   qn(64'sd293736230413011) },
        '{ qp(64'sd122645816904418000), qn(64'sd288342274075589000),
           qp(64'sd234042070424102000), qn(64'sd79965041589484400),
           qp(64'sd13276638451961700),  qn(64'sd1070060324061660),
           qp(64'sd33685111454948),
           qn(64'sd64747006832546900),  qp(64'sd131946332754611000),
           qn(64'sd67820160824866200),
           qp(64'sd742597280109346000), qp(64'sd248939193697005000),
           qp(64'sd8757262424062080),   qn(64'sd293736230412980) }
    };

    // gain lookup, the unused selector maps to the 30 V set
    function automatic logic signed [COEF_W-1:0] gain(logic [1:0] sel, logic [TAP_W-1:0] tap);
        logic [1:0] s;
        s = (sel == 2'd3) ? SET_30V : sel;
        if (tap >= TAP_W'(NUM_TAPS))
            return '0;
        return GAIN_ROM[s][tap];
    endfunction

    // operand source of a tap
    function automatic src_t tap_src(logic [TAP_W-1:0] tap);
        src_t s;
        unique case (tap) inside
            4'd0:    s = SRC_SETPOINT;
            4'd7:    s = SRC_MEASURED;
            default: s = SRC_HISTORY;
        endcase
        return s;
    endfunction

    // history region of a tap
    function automatic logic [REGION_W-1:0] tap_region(logic [TAP_W-1:0] tap);
        logic [REGION_W-1:0] r;
        unique case (tap) inside
            [4'd7:4'd9]:   r = REGION_MEASURED;
            [4'd10:4'd15]: r = REGION_DUTY;
            default:       r = REGION_SETPOINT;
        endcase
        return r;
    endfunction

    // age of the history entry a tap reads, zero is the newest
    function automatic logic [RING_W-1:0] tap_age(logic [TAP_W-1:0] tap);
        logic [TAP_W-1:0] a;
        unique case (tap) inside
            [4'd1:4'd6]:   a = tap - 4'd1;
            [4'd8:4'd9]:   a = tap - 4'd8;
            [4'd10:4'd13]: a = tap - 4'd10;
            default:       a = '0;
        endcase
        return a[RING_W-1:0];
    endfunction

endpackage

// ----- hw/rtl/rvc_hist_mac.sv -----
`timescale 1ns / 1ps
`include "rst_voltage_controller_core_defines.svh"

module rvc_hist_mac (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  rvc_pkg::mac_ctrl_t                       ctrl,
    input  logic signed [rvc_pkg::VOLT_W-1:0]        cur_sp,
    input  logic signed [rvc_pkg::VOLT_W-1:0]        cur_ms,
    output logic signed [rvc_pkg::ACC_W-1:0]         acc
);
    import rvc_pkg::*;

    logic [VOLT_W-1:0]         hist_mem [MEM_DEPTH];
    logic [VOLT_W-1:0]         rd_data_reg;
    logic [ADDR_W-1:0]         rd_addr;
    logic                      rd_live;
    logic [RING_W-1:0]         rd_age;

    logic                      s1_valid_reg;
    logic                      s1_live_reg;
    src_t                      s1_src_reg;
    logic                      s1_duty_reg;
    logic signed [COEF_W-1:0]  s1_coef_reg;
    logic signed [OPND_W-1:0]  operand;

    logic                      s2_valid_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [PROD_W-1:0]  prod_next;

    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W-1:0]   acc_next;

    // ring address of the entry this tap needs
    always_comb
    begin
        rd_age  = tap_age(ctrl.tap);
        rd_addr = {tap_region(ctrl.tap), ctrl.ptr - RING_W'(1) - rd_age};
        rd_live = rd_age < ctrl.fill;
    end

    // history memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            hist_mem[ctrl.wr_addr] <= ctrl.wr_data;
        end
        rd_data_reg <= hist_mem[rd_addr];
    end

    // tap attributes travel beside the read
    always_ff @(posedge clk)
    begin
        s1_live_reg <= rd_live;
        s1_src_reg  <= tap_src(ctrl.tap);
        s1_duty_reg <= tap_region(ctrl.tap) == REGION_DUTY;
        s1_coef_reg <= gain(ctrl.coef_sel, ctrl.tap);
        prod_reg    <= prod_next;
    end

    // operand select: current samples, stored history or zero before fill
    always_comb
    begin
        case (s1_src_reg)
            SRC_SETPOINT: operand = {cur_sp[VOLT_W-1], cur_sp};
            SRC_MEASURED: operand = {cur_ms[VOLT_W-1], cur_ms};
            default:
            begin
                if (!s1_live_reg)
                    operand = '0;
                else if (s1_duty_reg)
                    operand = {{(OPND_W-DUTY_W){1'b0}}, rd_data_reg[DUTY_W-1:0]};
                else
                    operand = {rd_data_reg[VOLT_W-1], rd_data_reg};
            end
        endcase
        prod_next = s1_coef_reg * operand;
    end

    // accumulate, cleared at the start of each transaction
    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.clear)
            acc_next = '0;
        else if (s2_valid_reg)
            acc_next = acc_reg + ACC_W'(prod_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            acc_reg      <= '0;
        end
        else
        begin
            s1_valid_reg <= ctrl.issue;
            s2_valid_reg <= s1_valid_reg;
            acc_reg      <= acc_next;
        end
    end

    assign acc = acc_reg;

    // a new sum starts only with the product pipeline empty
    `RVC_ASSERT_IMP(a_clear_drained, ctrl.clear, !s1_valid_reg && !s2_valid_reg)
    // a history read never hits the entry written in the same cycle
    `RVC_ASSERT_IMP(a_no_rw_clash, ctrl.wr_en && ctrl.issue && tap_src(ctrl.tap) == SRC_HISTORY, ctrl.wr_addr != rd_addr)
    // product pipeline advances one stage a cycle
    `RVC_ASSERT_NXT(a_pipe_advance, s1_valid_reg, s2_valid_reg)

endmodule

// ----- hw/rtl/rst_voltage_controller_core.sv -----
`timescale 1ns / 1ps
// RST duty controller for a boost converter. Each input transaction carries a setpoint and a
// measured voltage (signed Q8.16) and yields one output transaction with the duty command
// (Q0.16), clamped to [duty_min, duty_max], and a flag telling which bound was hit. The past
// duties, measurements and setpoints live in a 24-entry history memory; one shared
// multiply-accumulate walks the 14 taps of the S, R and T polynomials, one tap per cycle,
// followed by the pipeline drain steps and the clamp of the result. The next input is
// buffered while the current one is worked on, and the output register lets the next
// computation run while a result waits. The coefficient set (18, 24 or 30 V design) and
// the clamp limits are written through the configuration port; the user must do so only
// while the block is idle, which the block itself does not enforce.
`include "rst_voltage_controller_core_defines.svh"

module rst_voltage_controller_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration
    input  logic                                 cfg_write,
    input  logic [1:0]                           cfg_index,
    input  logic [rvc_pkg::DUTY_W-1:0]           cfg_data,
    // input channel
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [rvc_pkg::VOLT_W-1:0]    setpoint_v,
    input  logic signed [rvc_pkg::VOLT_W-1:0]    measured_v,
    // output channel
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [rvc_pkg::DUTY_W-1:0]           duty,
    output logic [1:0]                           clamp_state
);
    import rvc_pkg::*;

    state_t                    state_reg;
    state_t                    state_next;
    logic [TAP_W-1:0]          step_reg;
    logic [TAP_W-1:0]          step_next;
    logic [RING_W-1:0]         ptr_reg;
    logic [RING_W-1:0]         fill_reg;

    logic [1:0]                coefficient_set_reg;
    logic [DUTY_W-1:0]         duty_max_reg;
    logic [DUTY_W-1:0]         duty_min_reg;

    logic                      buf_valid_reg;
    logic signed [VOLT_W-1:0]  buf_sp_reg;
    logic signed [VOLT_W-1:0]  buf_ms_reg;
    logic signed [VOLT_W-1:0]  cur_sp_reg;
    logic signed [VOLT_W-1:0]  cur_ms_reg;

    logic                      out_valid_reg;
    logic [DUTY_W-1:0]         duty_reg;
    logic [1:0]                clamp_state_reg;

    logic                      in_take;
    logic                      out_free;
    logic                      start;
    logic                      finish;
    mac_ctrl_t                 ctrl;
    logic signed [ACC_W-1:0]   acc;
    logic signed [ACC_W-1:0]   acc_hi;
    logic signed [ACC_W-1:0]   acc_lo;
    logic [ACC_W-1:0]          acc_rnd;
    logic [DUTY_W-1:0]         duty_res;
    logic [1:0]                clamp_res;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coefficient_set_reg <= COEF_SET_RESET;
            duty_max_reg        <= DUTY_MAX_RESET;
            duty_min_reg        <= DUTY_MIN_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_COEFFICIENT_SET: coefficient_set_reg <= cfg_data[1:0];
                REG_DUTY_MAX:        duty_max_reg        <= cfg_data;
                REG_DUTY_MIN:        duty_min_reg        <= cfg_data;
                default:             ;
            endcase
        end
    end

    // handshake terms
    assign in_stall = buf_valid_reg;
    assign in_take  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign finish   = (state_reg == ST_DONE) && out_free;
    assign start    = buf_valid_reg && ((state_reg == ST_IDLE) || finish);

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_RUN;
                    step_next  = '0;
                end
            end
            ST_RUN:
            begin
                step_next = step_reg + TAP_W'(1);
                if (step_reg == LAST_STEP)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (start)
                begin
                    state_next = ST_RUN;
                    step_next  = '0;
                end
                else if (finish)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            ptr_reg       <= '0;
            fill_reg      <= '0;
            buf_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            if (finish)
            begin
                ptr_reg <= ptr_reg + RING_W'(1);
                if (fill_reg != FILL_MAX)
                    fill_reg <= fill_reg + RING_W'(1);
            end
            if (in_take)
                buf_valid_reg <= 1'b1;
            else if (start)
                buf_valid_reg <= 1'b0;
            if (finish)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // input buffer and working sample
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            buf_sp_reg <= setpoint_v;
            buf_ms_reg <= measured_v;
        end
        if (start)
        begin
            cur_sp_reg <= buf_sp_reg;
            cur_ms_reg <= buf_ms_reg;
        end
    end

    // datapath control: taps, sample writes early, duty write at finish
    always_comb
    begin
        ctrl          = '0;
        ctrl.clear    = start;
        ctrl.issue    = (state_reg == ST_RUN) && (step_reg < TAP_W'(NUM_TAPS));
        ctrl.tap      = step_reg;
        ctrl.ptr      = ptr_reg;
        ctrl.fill     = fill_reg;
        ctrl.coef_sel = coefficient_set_reg;
        if ((state_reg == ST_RUN) && (step_reg == TAP_W'(0)))
        begin
            ctrl.wr_en   = 1'b1;
            ctrl.wr_addr = {REGION_SETPOINT, ptr_reg};
            ctrl.wr_data = cur_sp_reg;
        end
        else if ((state_reg == ST_RUN) && (step_reg == TAP_W'(1)))
        begin
            ctrl.wr_en   = 1'b1;
            ctrl.wr_addr = {REGION_MEASURED, ptr_reg};
            ctrl.wr_data = cur_ms_reg;
        end
        else if (finish)
        begin
            ctrl.wr_en   = 1'b1;
            ctrl.wr_addr = {REGION_DUTY, ptr_reg};
            ctrl.wr_data = {{(VOLT_W-DUTY_W){1'b0}}, duty_res};
        end
    end

    rvc_hist_mac u_hist_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .cur_sp (cur_sp_reg),
        .cur_ms (cur_ms_reg),
        .acc    (acc)
    );

    // clamp and round to Q0.16
    always_comb
    begin
        acc_hi  = $signed({{(ACC_W-DUTY_W-FRAC_W){1'b0}}, duty_max_reg, {FRAC_W{1'b0}}});
        acc_lo  = $signed({{(ACC_W-DUTY_W-FRAC_W){1'b0}}, duty_min_reg, {FRAC_W{1'b0}}});
        acc_rnd = acc + $signed({{(ACC_W-FRAC_W){1'b0}}, 1'b1, {(FRAC_W-1){1'b0}}});
        if (acc > acc_hi)
        begin
            duty_res  = duty_max_reg;
            clamp_res = CLAMP_MAX;
        end
        else if (acc < acc_lo)
        begin
            duty_res  = duty_min_reg;
            clamp_res = CLAMP_MIN;
        end
        else
        begin
            duty_res  = acc_rnd[FRAC_W+DUTY_W-1:FRAC_W];
            clamp_res = CLAMP_NONE;
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            duty_reg        <= duty_res;
            clamp_state_reg <= clamp_res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign duty        = duty_reg;
    assign clamp_state = clamp_state_reg;

    // a finished sum waits while the output is held
    `RVC_ASSERT_NXT(a_done_waits, (state_reg == ST_DONE) && out_valid_reg && out_stall, state_reg == ST_DONE)
    // every finish loads a result
    `RVC_ASSERT_NXT(a_finish_loads, finish, out_valid_reg)
    // a buffered sample stays until the engine takes it
    `RVC_ASSERT_NXT(a_buf_holds, buf_valid_reg && !start, buf_valid_reg)
    // the reserved flag code never leaves the block
    `RVC_ASSERT_IMP(a_flag_code, out_valid_reg, clamp_state_reg != CLAMP_RESERVED)

endmodule
